FILE: src/ehrm_pkg.sv
// ehrm_pkg: shared types and constants of the emg activity / heart rate monitor
// no dependencies
package ehrm_pkg;

  localparam int unsigned IntervalCount = 10;
  localparam int unsigned MidFirst      = 3;
  localparam int unsigned MidLast       = 7;
  localparam int unsigned SumW          = 19;
  localparam int unsigned QuotW         = 19;
  localparam logic [QuotW-1:0] RateNum  = 19'd300000;
  localparam logic [15:0] RateNormalMin = 16'd60;

  typedef enum logic [3:0] {
    CFG_QUIET_DELTA  = 4'd0,
    CFG_FALL_MARGIN  = 4'd1,
    CFG_RUN_MIN      = 4'd2,
    CFG_PULSE_HIGH   = 4'd3,
    CFG_PULSE_LOW    = 4'd4,
    CFG_INTERVAL_MIN = 4'd5,
    CFG_INTERVAL_MAX = 4'd6,
    CFG_RATE_HIGH    = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] quiet_delta;
    logic [11:0] fall_margin;
    logic [15:0] run_min;
    logic [11:0] pulse_high;
    logic [11:0] pulse_low;
    logic [15:0] interval_min;
    logic [15:0] interval_max;
    logic [15:0] rate_high;
  } cfg_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic        active;
    logic        beat;
    logic        gap_ok;
    logic [15:0] gap;
  } rec_t;

endpackage

FILE: src/ehrm_front.sv
// ehrm_front: emg run counters and beat edge detection for each accepted word
// depends on ehrm_pkg
module ehrm_front import ehrm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        take_i,
  input  logic [11:0] emg_sample_i,
  input  logic [11:0] pulse_sample_i,
  input  logic [31:0] time_ms_i,
  output rec_t        rec_o
);

  logic [11:0] last_emg_q, last_pulse_q;
  logic [15:0] steady_q, steady_d, below_q, below_d;
  logic [31:0] last_beat_q, gap;
  logic [11:0] diff;
  logic [12:0] emg_lim;
  logic        beat;

  always_comb begin
    diff     = (emg_sample_i > last_emg_q) ? emg_sample_i - last_emg_q
                                           : last_emg_q - emg_sample_i;
    emg_lim  = {1'b0, last_emg_q} + {1'b0, cfg_i.fall_margin};
    steady_d = (diff <= cfg_i.quiet_delta) ?
               ((steady_q == 16'hFFFF) ? steady_q : steady_q + 16'd1) : 16'd0;
    below_d  = (emg_lim > {1'b0, emg_sample_i}) ?
               ((below_q == 16'hFFFF) ? below_q : below_q + 16'd1) : 16'd0;
    beat     = (pulse_sample_i > cfg_i.pulse_high) && (last_pulse_q < cfg_i.pulse_low);
    gap      = time_ms_i - last_beat_q;
    rec_o.active = (steady_d >= cfg_i.run_min) || (below_d >= cfg_i.run_min);
    rec_o.beat   = beat;
    rec_o.gap_ok = (gap > {16'd0, cfg_i.interval_min}) && (gap < {16'd0, cfg_i.interval_max});
    rec_o.gap    = gap[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_emg_q   <= '0;
      last_pulse_q <= '0;
      steady_q     <= '0;
      below_q      <= '0;
      last_beat_q  <= '0;
    end else if (take_i) begin
      last_emg_q   <= emg_sample_i;
      last_pulse_q <= pulse_sample_i;
      steady_q     <= steady_d;
      below_q      <= below_d;
      if (beat) begin
        last_beat_q <= time_ms_i;
      end
    end
  end

endmodule

FILE: src/ehrm_fifo.sv
// ehrm_fifo: two-entry queue of classified records between front and back
// depends on ehrm_pkg
module ehrm_fifo import ehrm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t din_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output rec_t dout_o,
  output logic [1:0] count_o
);

  rec_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign dout_o  = mem_q[rp_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

FILE: src/ehrm_back.sv
// ehrm_back: interval ring, serial sort, serial divide, rate history and result register
// depends on ehrm_pkg
module ehrm_back import ehrm_pkg::*; #(
  parameter int unsigned RateLookback = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        rec_valid_i,
  input  rec_t        rec_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] heart_rate_o,
  output logic        heart_normal_o,
  output logic        muscle_active_o,
  output logic        beat_seen_o
);

  typedef enum logic [2:0] {B_IDLE, B_SORT, B_SUM, B_DIV, B_UPD} bstate_e;

  bstate_e     state_q;
  logic [15:0] ring_q [IntervalCount];
  logic [15:0] srt_q  [IntervalCount];
  logic [15:0] srt_d  [IntervalCount];
  logic [15:0] hist_q [RateLookback];
  logic [3:0]  slot_q;
  logic [4:0]  cnt_q;
  logic        flag_q, flag_d, active_q;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [SumW:0]    rem_q, trial;
  logic [QuotW-1:0] quot_q;
  logic [15:0] rate;
  logic        older_fast;
  logic        out_valid_q, out_beat_q, out_active_q, out_flag_q;
  logic [15:0] out_rate_q;

  assign pop_o = (state_q == B_IDLE) && rec_valid_i && !out_valid_q;

  // one odd-even transposition pass
  always_comb begin
    for (int i = 0; i < IntervalCount; i++) srt_d[i] = srt_q[i];
    for (int i = 0; i + 1 < IntervalCount; i++) begin
      if ((i % 2) == int'(cnt_q[0]) && srt_q[i] > srt_q[i+1]) begin
        srt_d[i]   = srt_q[i+1];
        srt_d[i+1] = srt_q[i];
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = MidFirst; i <= MidLast; i++) sum_d = sum_d + {3'd0, srt_q[i]};
    trial = {rem_q[SumW-1:0], quot_q[QuotW-1]};
    rate  = (quot_q[QuotW-1:16] != '0) ? 16'hFFFF : quot_q[15:0];
    older_fast = 1'b1;
    for (int k = 0; k + 1 < RateLookback; k++) begin
      if (hist_q[k] <= cfg_i.rate_high) older_fast = 1'b0;
    end
    flag_d = flag_q;
    if (rate > cfg_i.rate_high) begin
      flag_d = !older_fast;
    end else if (rate >= RateNormalMin) begin
      flag_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      slot_q       <= '0;
      flag_q       <= 1'b1;
      cnt_q        <= '0;
      active_q     <= 1'b0;
      sum_q        <= '0;
      rem_q        <= '0;
      quot_q       <= '0;
      out_valid_q  <= 1'b0;
      out_rate_q   <= '0;
      out_flag_q   <= 1'b1;
      out_active_q <= 1'b0;
      out_beat_q   <= 1'b0;
      for (int i = 0; i < IntervalCount; i++) ring_q[i] <= '0;
      for (int i = 0; i < IntervalCount; i++) srt_q[i] <= '0;
      for (int k = 0; k < RateLookback; k++) hist_q[k] <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            active_q <= rec_i.active;
            if (rec_i.beat) begin
              for (int i = 0; i < IntervalCount; i++) begin
                srt_q[i] <= (rec_i.gap_ok && slot_q == 4'(i)) ? rec_i.gap : ring_q[i];
              end
              if (rec_i.gap_ok) begin
                ring_q[slot_q] <= rec_i.gap;
                slot_q <= (slot_q == 4'(IntervalCount - 1)) ? 4'd0 : slot_q + 4'd1;
              end
              cnt_q   <= '0;
              state_q <= B_SORT;
            end else begin
              out_valid_q  <= 1'b1;
              out_rate_q   <= hist_q[0];
              out_flag_q   <= flag_q;
              out_active_q <= rec_i.active;
              out_beat_q   <= 1'b0;
            end
          end
        end
        B_SORT: begin
          for (int i = 0; i < IntervalCount; i++) srt_q[i] <= srt_d[i];
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(IntervalCount - 1)) state_q <= B_SUM;
        end
        B_SUM: begin
          sum_q  <= sum_d;
          rem_q  <= '0;
          quot_q <= RateNum;
          cnt_q  <= '0;
          if (sum_d == '0) begin
            out_valid_q  <= 1'b1;
            out_rate_q   <= hist_q[0];
            out_flag_q   <= flag_q;
            out_active_q <= active_q;
            out_beat_q   <= 1'b1;
            state_q      <= B_IDLE;
          end else begin
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (trial >= {1'b0, sum_q}) begin
            rem_q  <= trial - {1'b0, sum_q};
            quot_q <= {quot_q[QuotW-2:0], 1'b1};
          end else begin
            rem_q  <= trial;
            quot_q <= {quot_q[QuotW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(QuotW - 1)) state_q <= B_UPD;
        end
        B_UPD: begin
          for (int k = RateLookback - 1; k > 0; k--) hist_q[k] <= hist_q[k-1];
          hist_q[0] <= rate;
          out_valid_q  <= 1'b1;
          out_rate_q   <= rate;
          out_active_q <= active_q;
          out_beat_q   <= 1'b1;
          out_flag_q   <= flag_d;
          flag_q       <= flag_d;
          state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign heart_rate_o    = out_rate_q;
  assign heart_normal_o  = out_flag_q;
  assign muscle_active_o = out_active_q;
  assign beat_seen_o     = out_beat_q;

endmodule

FILE: src/emg_activity_heart_rate_monitor_top.sv
// emg_activity_heart_rate_monitor_top: top level, configuration registers and assertions
// depends on ehrm_pkg, ehrm_front, ehrm_fifo, ehrm_back
//
// Each accepted sample gives one result. The front classifies a sample in the cycle it is
// accepted and queues it in a two-entry queue. A sample without a beat edge is answered
// via the result register; a beat runs in the back end through 10 odd-even sort passes
// over the interval ring, one summing step, a 19-bit bit-serial divider and one update.
// Input is stalled only while the queue is full. Configuration writes are always ready.
module emg_activity_heart_rate_monitor_top import ehrm_pkg::*; #(
  parameter int unsigned RATE_LOOKBACK = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] emg_sample_i,
  input  logic [11:0] pulse_sample_i,
  input  logic [31:0] time_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] heart_rate_o,
  output logic        heart_normal_o,
  output logic        muscle_active_o,
  output logic        beat_seen_o
);

  cfg_t       cfg_q;
  rec_t       front_rec, queue_rec;
  logic       take, full, q_valid, pop;
  logic [1:0] q_count;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign take        = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quiet_delta  <= 12'd80;
      cfg_q.fall_margin  <= 12'd40;
      cfg_q.run_min      <= 16'd5;
      cfg_q.pulse_high   <= 12'd4000;
      cfg_q.pulse_low    <= 12'd80;
      cfg_q.interval_min <= 16'd300;
      cfg_q.interval_max <= 16'd2000;
      cfg_q.rate_high    <= 16'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_QUIET_DELTA:  cfg_q.quiet_delta  <= cfg_data_i[11:0];
        CFG_FALL_MARGIN:  cfg_q.fall_margin  <= cfg_data_i[11:0];
        CFG_RUN_MIN:      cfg_q.run_min      <= cfg_data_i;
        CFG_PULSE_HIGH:   cfg_q.pulse_high   <= cfg_data_i[11:0];
        CFG_PULSE_LOW:    cfg_q.pulse_low    <= cfg_data_i[11:0];
        CFG_INTERVAL_MIN: cfg_q.interval_min <= cfg_data_i;
        CFG_INTERVAL_MAX: cfg_q.interval_max <= cfg_data_i;
        CFG_RATE_HIGH:    cfg_q.rate_high    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ehrm_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .take_i(take),
    .emg_sample_i, .pulse_sample_i, .time_ms_i, .rec_o(front_rec)
  );

  ehrm_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(take), .din_i(front_rec), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .dout_o(queue_rec), .count_o(q_count)
  );

  ehrm_back #(.RateLookback(RATE_LOOKBACK)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .rec_valid_i(q_valid), .rec_i(queue_rec),
    .pop_o(pop), .out_valid_o, .out_stall_i, .heart_rate_o, .heart_normal_o,
    .muscle_active_o, .beat_seen_o
  );

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count != 2'd3) else $error("queue count overflow");
  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !out_valid_o) else $error("pop while result pending");
  a_quiet_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !queue_rec.beat |=> out_valid_o && !beat_seen_o)
    else $error("non-beat sample not answered next cycle");
`endif

endmodule
